// ===== hdl/ppul_pkg.sv =====
`default_nettype none
package ppul_pkg;

  localparam int ITERATIONS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int PIX_FRAC       = 4;
  localparam int INVF_FRAC      = 32;

  // register indexes
  localparam logic [2:0] REG_K1 = 3'd0;
  localparam logic [2:0] REG_K2 = 3'd1;
  localparam logic [2:0] REG_P1 = 3'd2;
  localparam logic [2:0] REG_P2 = 3'd3;
  localparam logic [2:0] REG_IFX = 3'd4;
  localparam logic [2:0] REG_IFY = 3'd5;
  localparam logic [2:0] REG_CX = 3'd6;
  localparam logic [2:0] REG_CY = 3'd7;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } ppul_req_t;

  typedef struct packed {
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               saturated;
  } ppul_rsp_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } ppul_coef_t;

  // point travelling down the chain; lsat is clipping in the lift alone
  typedef struct packed {
    logic signed [31:0] xd;
    logic signed [31:0] yd;
    logic signed [31:0] xu;
    logic signed [31:0] yu;
    logic               sat;
    logic               lsat;
  } ppul_item_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } ppul_sat_t;

  function automatic logic signed [63:0] sx32(input logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic ppul_sat_t sat32(input logic signed [63:0] v);
    ppul_sat_t r;
    if (v > 64'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  // round half up, arithmetic shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic ppul_sat_t qmul(input logic signed [31:0] a,
                                     input logic signed [31:0] b, input int frac);
    logic signed [63:0] p;
    p = sx32(a) * sx32(b);
    return sat32(rnd(p, frac));
  endfunction

  // copy of a point with a new clip flag
  function automatic ppul_item_t with_sat(input ppul_item_t it, input logic s);
    ppul_item_t r;
    r     = it;
    r.sat = s;
    return r;
  endfunction

  // copy of a point with a new estimate and clip flag
  function automatic ppul_item_t with_est(input ppul_item_t it,
                                          input logic signed [31:0] xu,
                                          input logic signed [31:0] yu, input logic s);
    ppul_item_t r;
    r     = it;
    r.xu  = xu;
    r.yu  = yu;
    r.sat = s;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ppul_lift_cell.sv =====
`default_nettype none
module ppul_lift_cell import ppul_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire ppul_req_t   req_i,
  input  wire logic [39:0] inv_fx_i,
  input  wire logic [39:0] inv_fy_i,
  input  wire logic [15:0] cx_i,
  input  wire logic [15:0] cy_i,
  output logic             valid_o,
  output ppul_item_t       item_o
);
  localparam int Shift = PIX_FRAC + INVF_FRAC - FRAC_BITS;

  logic               va_q, vb_q;
  logic signed [57:0] px_q, py_q;
  logic signed [16:0] dx, dy;
  ppul_sat_t          lx, ly;
  ppul_item_t         it_q;

  assign dx = $signed({1'b0, req_i.pixel_x}) - $signed({1'b0, cx_i});
  assign dy = $signed({1'b0, req_i.pixel_y}) - $signed({1'b0, cy_i});
  assign lx = sat32(rnd(64'(px_q), Shift));
  assign ly = sat32(rnd(64'(py_q), Shift));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= $signed({1'b0, inv_fx_i}) * dx;
      py_q    <= $signed({1'b0, inv_fy_i}) * dy;
      it_q.xd <= lx.val;
      it_q.yd <= ly.val;
      it_q.xu <= lx.val;
      it_q.yu <= ly.val;
      it_q.sat  <= lx.clip | ly.clip;
      it_q.lsat <= lx.clip | ly.clip;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = it_q;
endmodule
`default_nettype wire

// ===== hdl/ppul_iter_cell.sv =====
`default_nettype none
module ppul_iter_cell import ppul_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire ppul_coef_t coef_i,
  input  wire logic       valid_i,
  input  wire ppul_item_t item_i,
  output logic            valid_o,
  output ppul_item_t      item_o
);
  // seven stages: squares, rho2/tangential terms, coefficient products,
  // k2 term, radial factor, scaling by the point, final sums
  logic [6:0] v_q;
  ppul_item_t it1_q, it2_q, it3_q, it4_q, it5_q, it6_q, it7_q;
  logic signed [31:0] mx2_q, my2_q, mxy_q;
  logic signed [31:0] rho2_q, tx_q, ty_q, pm1_q, pm2_q, pm1b_q, pm2b_q, pm1c_q, pm2c_q,
                      pm1d_q, pm2d_q, pm1e_q, pm2e_q;
  logic signed [31:0] rho4_q, kr1_q, ptx_q, pty_q, kr1b_q, ptxb_q, ptyb_q;
  logic signed [31:0] kr2_q, rad_q, ptxc_q, ptyc_q, ptxd_q, ptyd_q, xr_q, yr_q;

  ppul_sat_t m_xx, m_yy, m_xy, s_rho2, s_tx, s_ty, m_p1, m_p2;
  ppul_sat_t m_r4, m_k1, m_ptx, m_pty, m_k2, s_rad, m_xr, m_yr;
  ppul_sat_t s_dx, s_dy, s_xu, s_yu;

  assign m_xx = qmul(item_i.xu, item_i.xu, FRAC_BITS);
  assign m_yy = qmul(item_i.yu, item_i.yu, FRAC_BITS);
  assign m_xy = qmul(item_i.xu, item_i.yu, FRAC_BITS);

  assign s_rho2 = sat32(sx32(mx2_q) + sx32(my2_q));
  assign s_tx   = sat32(sx32(s_rho2.val) + (sx32(mx2_q) <<< 1));
  assign s_ty   = sat32(sx32(s_rho2.val) + (sx32(my2_q) <<< 1));
  assign m_p1   = qmul(coef_i.p1, mxy_q, FRAC_BITS);
  assign m_p2   = qmul(coef_i.p2, mxy_q, FRAC_BITS);

  assign m_r4  = qmul(rho2_q, rho2_q, FRAC_BITS);
  assign m_k1  = qmul(coef_i.k1, rho2_q, FRAC_BITS);
  assign m_ptx = qmul(coef_i.p2, tx_q, FRAC_BITS);
  assign m_pty = qmul(coef_i.p1, ty_q, FRAC_BITS);

  assign m_k2  = qmul(coef_i.k2, rho4_q, FRAC_BITS);
  assign s_rad = sat32(sx32(kr1b_q) + sx32(kr2_q));

  assign m_xr = qmul(it5_q.xu, rad_q, FRAC_BITS);
  assign m_yr = qmul(it5_q.yu, rad_q, FRAC_BITS);

  assign s_dx = sat32(sx32(xr_q) + (sx32(pm1e_q) <<< 1) + sx32(ptxd_q));
  assign s_dy = sat32(sx32(yr_q) + (sx32(pm2e_q) <<< 1) + sx32(ptyd_q));
  assign s_xu = sat32(sx32(it6_q.xd) - sx32(s_dx.val));
  assign s_yu = sat32(sx32(it6_q.yd) - sx32(s_dy.val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q <= with_sat(item_i, item_i.sat | m_xx.clip | m_yy.clip | m_xy.clip);
      mx2_q <= m_xx.val;
      my2_q <= m_yy.val;
      mxy_q <= m_xy.val;

      it2_q  <= with_sat(it1_q, it1_q.sat | s_rho2.clip | s_tx.clip | s_ty.clip |
                         m_p1.clip | m_p2.clip);
      rho2_q <= s_rho2.val;
      tx_q   <= s_tx.val;
      ty_q   <= s_ty.val;
      pm1_q  <= m_p1.val;
      pm2_q  <= m_p2.val;

      it3_q  <= with_sat(it2_q, it2_q.sat | m_r4.clip | m_k1.clip | m_ptx.clip |
                         m_pty.clip);
      rho4_q <= m_r4.val;
      kr1_q  <= m_k1.val;
      ptx_q  <= m_ptx.val;
      pty_q  <= m_pty.val;
      pm1b_q <= pm1_q;
      pm2b_q <= pm2_q;

      it4_q  <= with_sat(it3_q, it3_q.sat | m_k2.clip);
      kr2_q  <= m_k2.val;
      kr1b_q <= kr1_q;
      ptxb_q <= ptx_q;
      ptyb_q <= pty_q;
      pm1c_q <= pm1b_q;
      pm2c_q <= pm2b_q;

      it5_q  <= with_sat(it4_q, it4_q.sat | s_rad.clip);
      rad_q  <= s_rad.val;
      ptxc_q <= ptxb_q;
      ptyc_q <= ptyb_q;
      pm1d_q <= pm1c_q;
      pm2d_q <= pm2c_q;

      it6_q  <= with_sat(it5_q, it5_q.sat | m_xr.clip | m_yr.clip);
      xr_q   <= m_xr.val;
      yr_q   <= m_yr.val;
      ptxd_q <= ptxc_q;
      ptyd_q <= ptyc_q;
      pm1e_q <= pm1d_q;
      pm2e_q <= pm2d_q;

      it7_q <= with_est(it6_q, s_xu.val, s_yu.val,
                        it6_q.sat | s_dx.clip | s_dy.clip | s_xu.clip | s_yu.clip);
    end
  end

  assign valid_o = v_q[6];
  assign item_o  = it7_q;
endmodule
`default_nettype wire

// ===== hdl/pixel_point_undistort_lift_top.sv =====
`default_nettype none
// Channel   Dir  Handshake                 Payload
// request   in   in_valid_i / in_ready_o   in_req_i  (pixel_x, pixel_y)
// response  out  out_valid_o / out_ready_i out_rsp_o (norm_x, norm_y, saturated)
// config    in   APB psel/penable/pwrite   paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// One request per cycle sustained while responses are taken; the chain holds two lift
// stages, seven stages per iteration cell and one output register.
// Every stage advances together; a held response freezes the whole chain, so
// in_ready_o follows the output register being free or being taken.
// Reset clears the valid bits and loads the register reset values.
// With all coefficients zero the plain lift is returned, chosen at the output.
module pixel_point_undistort_lift_top import ppul_pkg::*; #(
  parameter int ITERATIONS = ITERATIONS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire ppul_req_t   in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output ppul_rsp_t        out_rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  logic        adv;
  logic [2:0]  ridx;
  logic        wr;
  ppul_coef_t  coef_q;
  logic [39:0] ifx_q, ify_q;
  logic [15:0] cx_q, cy_q;
  logic        coef_zero;

  logic       cv   [ITERATIONS+1];
  ppul_item_t citem[ITERATIONS+1];

  logic      ov_q;
  ppul_rsp_t rsp_q;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];
  assign wr     = psel & penable & pwrite;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      ifx_q  <= 40'h01_0000_0000;
      ify_q  <= 40'h01_0000_0000;
      cx_q   <= '0;
      cy_q   <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_K1:  coef_q.k1 <= pwdata[31:0];
        REG_K2:  coef_q.k2 <= pwdata[31:0];
        REG_P1:  coef_q.p1 <= pwdata[31:0];
        REG_P2:  coef_q.p2 <= pwdata[31:0];
        REG_IFX: ifx_q     <= pwdata[39:0];
        REG_IFY: ify_q     <= pwdata[39:0];
        REG_CX:  cx_q      <= pwdata[15:0];
        REG_CY:  cy_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      REG_K1:  prdata = {{32{coef_q.k1[31]}}, coef_q.k1};
      REG_K2:  prdata = {{32{coef_q.k2[31]}}, coef_q.k2};
      REG_P1:  prdata = {{32{coef_q.p1[31]}}, coef_q.p1};
      REG_P2:  prdata = {{32{coef_q.p2[31]}}, coef_q.p2};
      REG_IFX: prdata = {24'd0, ifx_q};
      REG_IFY: prdata = {24'd0, ify_q};
      REG_CX:  prdata = {48'd0, cx_q};
      REG_CY:  prdata = {48'd0, cy_q};
      default: prdata = '0;
    endcase
  end

  assign coef_zero = (coef_q == '0);

  // whole chain moves when the output slot is free or being emptied
  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  ppul_lift_cell #(.FRAC_BITS(FRAC_BITS)) u_lift (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(in_valid_i), .req_i(in_req_i),
    .inv_fx_i(ifx_q), .inv_fy_i(ify_q), .cx_i(cx_q), .cy_i(cy_q),
    .valid_o(cv[0]), .item_o(citem[0])
  );

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
    ppul_iter_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i, .rst_ni, .en_i(adv), .coef_i(coef_q),
      .valid_i(cv[g]), .item_i(citem[g]),
      .valid_o(cv[g+1]), .item_o(citem[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= cv[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q.norm_x    <= coef_zero ? citem[ITERATIONS].xd : citem[ITERATIONS].xu;
      rsp_q.norm_y    <= coef_zero ? citem[ITERATIONS].yd : citem[ITERATIONS].yu;
      rsp_q.saturated <= coef_zero ? citem[ITERATIONS].lsat : citem[ITERATIONS].sat;
    end
  end

  assign out_valid_o = ov_q;
  assign out_rsp_o   = rsp_q;

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(cv[0]) && $stable(cv[ITERATIONS])))
    else $error("chain moved while stalled");

  a_rise_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(adv))
    else $error("response appeared without an advance");

  a_stall_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("held response changed");

endmodule
`default_nettype wire
